// File: hdl/lavm_pkg.sv
// Shared constants and types for the look-at view matrix block.
// No dependencies; compiled first.
`default_nettype none

package lavm_pkg;

    // Field widths of the camera and row channels
    localparam int COORD_WIDTH   = 32;
    localparam int ENTRY_WIDTH   = 18;
    localparam int SHIFT_WIDTH   = 32;
    localparam int ROW_IDX_WIDTH = 2;

    // Signed width of a vector handed to the normalizer
    localparam int NORM_IN_WIDTH = 36;

    // Working width for rounding and saturation
    localparam int CALC_WIDTH    = 72;

    typedef logic [ROW_IDX_WIDTH-1:0] t_row_idx;

    // Row codes
    localparam t_row_idx ROW_U = 2'd0;
    localparam t_row_idx ROW_V = 2'd1;
    localparam t_row_idx ROW_W = 2'd2;

endpackage

`default_nettype wire

// File: hdl/lavm_if.sv
// Valid/ready channel interfaces: camera items in, matrix rows out.
// Depends on lavm_pkg for field widths.
`default_nettype none

interface lavm_cam_if;
    logic valid;
    logic ready;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] pos_x;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] pos_y;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] pos_z;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] look_x;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] look_y;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] look_z;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] up_x;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] up_y;
    logic signed [lavm_pkg::COORD_WIDTH-1:0] up_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z, up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, look_x, look_y, look_z, up_x, up_y, up_z,
        output ready
    );
endinterface

interface lavm_row_if;
    logic valid;
    logic ready;
    lavm_pkg::t_row_idx row_index;
    logic signed [lavm_pkg::ENTRY_WIDTH-1:0] entry_x;
    logic signed [lavm_pkg::ENTRY_WIDTH-1:0] entry_y;
    logic signed [lavm_pkg::ENTRY_WIDTH-1:0] entry_z;
    logic signed [lavm_pkg::SHIFT_WIDTH-1:0] shift_term;
    logic degenerate;
    logic last_row;

    modport source (
        output valid, row_index, entry_x, entry_y, entry_z, shift_term, degenerate,
        output last_row,
        input  ready
    );
    modport sink (
        input  valid, row_index, entry_x, entry_y, entry_z, shift_term, degenerate,
        input  last_row,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/lavm_norm.sv
// Pipelined 3-vector normalizer: magnitude scaling, bit-serial square root
// one bit per stage, then three restoring dividers one quotient bit per stage.
// Depends on lavm_pkg.
`default_nettype none

module lavm_norm #(
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_en,
    input  wire logic                                      i_valid,
    input  wire logic signed [lavm_pkg::NORM_IN_WIDTH-1:0] i_vec [3],
    input  wire logic [SB_W-1:0]                           i_sb,
    output logic                                           o_valid,
    output logic                                           o_ok,
    output logic signed [FRAC_BITS+1:0]                    o_vec [3],
    output logic [SB_W-1:0]                                o_sb
);

    localparam int IN_W  = lavm_pkg::NORM_IN_WIDTH;
    localparam int MW    = 31;              // scaled magnitude width
    localparam int LW    = $clog2(IN_W + 1);
    localparam int N_W   = 2 * MW + 2;      // sum of squares
    localparam int RT_W  = MW + 1;          // root bits, one per stage
    localparam int REM_W = RT_W + 4;
    localparam int QW    = FRAC_BITS + 1;   // quotient bits, one per stage
    localparam int NUM_W = MW + QW;
    localparam int EW    = FRAC_BITS + 2;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    typedef struct packed {
        logic [SB_W-1:0]      sb;
        logic                 zero;
        logic [2:0]           neg;
        logic [2:0][MW-1:0]   mag;
    } t_ctx;

    // Stage 1: magnitudes and their OR
    logic [2:0][IN_W-1:0] n1_mag;
    logic [IN_W-1:0]      n1_or;
    logic                 r1_v;
    logic [2:0][IN_W-1:0] r1_mag;
    logic [2:0]           r1_neg;
    logic [IN_W-1:0]      r1_or;
    logic [SB_W-1:0]      r1_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_vec[i][IN_W-1] ? IN_W'(-i_vec[i]) : IN_W'(i_vec[i]);
        end
        n1_or = n1_mag[0] | n1_mag[1] | n1_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= i_vec[i][IN_W-1];
            end
            r1_mag <= n1_mag;
            r1_or  <= n1_or;
            r1_sb  <= i_sb;
        end
    end

    // Stage 2: bit length of the largest magnitude
    logic [LW-1:0]        n2_len;
    logic                 r2_v;
    logic [LW-1:0]        r2_len;
    logic                 r2_zero;
    logic [2:0][IN_W-1:0] r2_mag;
    logic [2:0]           r2_neg;
    logic [SB_W-1:0]      r2_sb;

    always_comb begin
        n2_len = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (r1_or[b]) n2_len = LW'(b + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_len  <= n2_len;
            r2_zero <= (r1_or == '0);
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_sb   <= r1_sb;
        end
    end

    // Stage 3: shift so the largest magnitude has its top bit at bit 30
    t_ctx            n3_ctx;
    logic [IN_W-1:0] w_sh [3];
    logic            r3_v;
    t_ctx            r3_ctx;

    always_comb begin
        n3_ctx.sb   = r2_sb;
        n3_ctx.zero = r2_zero;
        n3_ctx.neg  = r2_neg;
        for (int i = 0; i < 3; i++) begin
            if (r2_len > LW'(MW)) begin
                w_sh[i] = r2_mag[i] >> (r2_len - LW'(MW));
            end else begin
                w_sh[i] = r2_mag[i] << (LW'(MW) - r2_len);
            end
            n3_ctx.mag[i] = w_sh[i][MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r3_ctx <= n3_ctx;
    end

    // Stage 4: squares
    logic                  r4_v;
    t_ctx                  r4_ctx;
    logic [2:0][2*MW-1:0]  r4_sq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ctx <= r3_ctx;
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= (2*MW)'(r3_ctx.mag[i]) * (2*MW)'(r3_ctx.mag[i]);
            end
        end
    end

    // Square root pipeline, entry 0 holds the sum of squares
    logic             r_sq_v    [RT_W+1];
    logic [N_W-1:0]   r_sq_n    [RT_W+1];
    logic [REM_W-1:0] r_sq_rem  [RT_W+1];
    logic [RT_W-1:0]  r_sq_root [RT_W+1];
    t_ctx             r_sq_ctx  [RT_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_n[0]    <= N_W'(r4_sq[0]) + N_W'(r4_sq[1]) + N_W'(r4_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_ctx[0]  <= r4_ctx;
        end
    end

    for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
        logic [REM_W-1:0] w_rem;
        logic [REM_W-1:0] w_try;
        logic             w_ge;

        always_comb begin
            w_rem = {r_sq_rem[k][REM_W-3:0], r_sq_n[k][N_W-1 -: 2]};
            w_try = REM_W'({r_sq_root[k], 2'b01});
            w_ge  = (w_rem >= w_try);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_n[k+1]    <= r_sq_n[k] << 2;
                r_sq_rem[k+1]  <= w_ge ? (w_rem - w_try) : w_rem;
                r_sq_root[k+1] <= {r_sq_root[k][RT_W-2:0], w_ge};
                r_sq_ctx[k+1]  <= r_sq_ctx[k];
            end
        end
    end

    // Divider pipeline, entry 0 holds rounded numerators
    logic                 r_dv_v   [QW+1];
    logic [RT_W-1:0]      r_dv_len [QW+1];
    logic [2:0][RT_W-1:0] r_dv_rem [QW+1];
    logic [2:0][QW-1:0]   r_dv_lo  [QW+1];
    logic [2:0][QW-1:0]   r_dv_q   [QW+1];
    t_ctx                 r_dv_ctx [QW+1];
    logic [NUM_W-1:0]     w_num    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = (NUM_W'(r_sq_ctx[RT_W].mag[i]) << FRAC_BITS)
                     + NUM_W'(r_sq_root[RT_W] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_len[0] <= r_sq_root[RT_W];
            r_dv_ctx[0] <= r_sq_ctx[RT_W];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= RT_W'(w_num[i][NUM_W-1:QW]);
                r_dv_lo[0][i]  <= w_num[i][QW-1:0];
                r_dv_q[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [RT_W:0]        w_t   [3];
        logic [2:0]           w_ge;
        logic [RT_W:0]        w_len;

        always_comb begin
            w_len = {1'b0, r_dv_len[j]};
            for (int i = 0; i < 3; i++) begin
                w_t[i]  = {r_dv_rem[j][i], r_dv_lo[j][i][QW-1]};
                w_ge[i] = (w_t[i] >= w_len);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_len[j+1] <= r_dv_len[j];
                r_dv_ctx[j+1] <= r_dv_ctx[j];
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j+1][i] <= w_ge[i] ? RT_W'(w_t[i] - w_len) : w_t[i][RT_W-1:0];
                    r_dv_q[j+1][i]   <= {r_dv_q[j][i][QW-2:0], w_ge[i]};
                    r_dv_lo[j+1][i]  <= r_dv_lo[j][i] << 1;
                end
            end
        end
    end

    // Output stage: clamp, sign, zero vector
    logic                r_o_v;
    logic                r_o_ok;
    logic signed [EW-1:0] r_o_vec [3];
    logic [SB_W-1:0]     r_o_sb;
    logic [QW-1:0]       w_qc  [3];
    logic signed [EW-1:0] w_val [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qc[i]  = (r_dv_q[QW][i] > ONE_Q) ? ONE_Q : r_dv_q[QW][i];
            w_val[i] = $signed(EW'(w_qc[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_ok <= !r_dv_ctx[QW].zero;
            r_o_sb <= r_dv_ctx[QW].sb;
            for (int i = 0; i < 3; i++) begin
                if (r_dv_ctx[QW].zero) begin
                    r_o_vec[i] <= '0;
                end else if (r_dv_ctx[QW].neg[i]) begin
                    r_o_vec[i] <= -w_val[i];
                end else begin
                    r_o_vec[i] <= w_val[i];
                end
            end
        end
    end

    // Valid chain for the front stages and the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r_sq_v[0] <= 1'b0;
            r_dv_v[0] <= 1'b0;
            r_o_v     <= 1'b0;
        end else if (i_en) begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r_sq_v[0] <= r4_v;
            r_dv_v[0] <= r_sq_v[RT_W];
            r_o_v     <= r_dv_v[QW];
        end
    end

    assign o_valid = r_o_v;
    assign o_ok    = r_o_ok;
    assign o_vec   = r_o_vec;
    assign o_sb    = r_o_sb;

endmodule

`default_nettype wire

// File: hdl/look_at_view_matrix.sv
// Look-at view matrix top level: two normalizers, projection, cross product,
// translation and a three-row output register. Depends on lavm_pkg, lavm_if, lavm_norm.
`default_nettype none

// Each camera item (position, look, up in signed fixed point with FRAC_BITS
// fraction bits) produces three row items in the order u, v, w, each with
// three rotation entries and the translation -(row . pos) saturated to 32 bits.
// A zero look vector, or an up vector parallel to look, gives zero rows with
// degenerate set. The row channel carries one row per cycle while o_row.ready
// is high, and each item has three rows; a new camera item is taken only when
// the last row of the previous one is accepted or the output is empty. The
// datapath is fully pipelined (one step of square root or division per stage).
// A stall on the row channel holds the whole pipeline.
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    lavm_cam_if.sink    i_cam,
    lavm_row_if.source  o_row
);

    localparam int F   = FRAC_BITS;
    localparam int EW  = F + 2;
    localparam int CW  = lavm_pkg::COORD_WIDTH;
    localparam int NW  = lavm_pkg::NORM_IN_WIDTH;
    localparam int XW  = lavm_pkg::CALC_WIDTH;
    localparam int ENW = lavm_pkg::ENTRY_WIDTH;
    localparam int SHW = lavm_pkg::SHIFT_WIDTH;
    localparam int PW  = CW + EW;
    localparam int SW  = PW + 2;
    localparam int DW  = CW + 2;
    localparam int QPW = DW + EW;
    localparam int XPW = 2 * EW;
    localparam int TRW = CW + 4;
    localparam int SB1 = 6 * CW;
    localparam int SB2 = 3 * CW + 3 * EW + 1;

    localparam logic [XW-1:0]        HALF    = XW'(1) << (F - 1);
    localparam logic signed [XW-1:0] ONE     = XW'(1) << F;
    localparam logic signed [XW-1:0] SAT_MAX = XW'(32'h7FFF_FFFF);
    localparam logic signed [XW-1:0] SAT_MIN = -(XW'(1) << (SHW - 1));

    // Round to nearest, ties away from zero, shift right by F
    function automatic logic signed [XW-1:0] f_rnd(input logic signed [XW-1:0] x);
        logic [XW-1:0] a;
        a = x[XW-1] ? XW'(-x) : XW'(x);
        a = (a + HALF) >> F;
        return x[XW-1] ? -$signed(a) : $signed(a);
    endfunction

    function automatic logic signed [EW-1:0] f_clamp(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] c;
        c = x;
        if (x > ONE) c = ONE;
        if (x < -ONE) c = -ONE;
        return EW'(c);
    endfunction

    function automatic logic signed [SHW-1:0] f_sat_neg(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] t;
        t = -x;
        if (t > SAT_MAX) t = SAT_MAX;
        if (t < SAT_MIN) t = SAT_MIN;
        return SHW'(t);
    endfunction

    function automatic logic signed [ENW-1:0] f_ent(input logic signed [EW-1:0] e);
        logic signed [XW-1:0] t;
        t = XW'(e);
        return t[ENW-1:0];
    endfunction

    logic w_adv;

    // Front normalizer: w = normalize(-look), position and up ride along
    logic signed [NW-1:0] w_nlook [3];
    logic [SB1-1:0]       w_sb1_in;
    logic                 w_n1_v;
    logic                 w_n1_ok;
    logic signed [EW-1:0] w_n1_w  [3];
    logic [SB1-1:0]       w_n1_sb;
    logic signed [CW-1:0] w_n1_pos [3];
    logic signed [CW-1:0] w_n1_up  [3];

    assign w_nlook[0] = -NW'(i_cam.look_x);
    assign w_nlook[1] = -NW'(i_cam.look_y);
    assign w_nlook[2] = -NW'(i_cam.look_z);
    assign w_sb1_in   = {i_cam.pos_x, i_cam.pos_y, i_cam.pos_z,
                         i_cam.up_x, i_cam.up_y, i_cam.up_z};

    lavm_norm #(
        .FRAC_BITS (F),
        .SB_W      (SB1)
    ) u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_cam.valid),
        .i_vec   (w_nlook),
        .i_sb    (w_sb1_in),
        .o_valid (w_n1_v),
        .o_ok    (w_n1_ok),
        .o_vec   (w_n1_w),
        .o_sb    (w_n1_sb)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n1_pos[i] = $signed(w_n1_sb[(5 - i) * CW +: CW]);
            w_n1_up[i]  = $signed(w_n1_sb[(2 - i) * CW +: CW]);
        end
    end

    // Up projection stages: d = rnd(up . w), r = up - rnd(d * w)
    logic r_d1_v, r_d2_v, r_d3_v, r_d4_v, r_d5_v, r_d6_v;
    logic r_d1_ok, r_d2_ok, r_d3_ok, r_d4_ok, r_d5_ok, r_d6_ok;
    logic signed [CW-1:0]  r_d1_pos [3], r_d2_pos [3], r_d3_pos [3];
    logic signed [CW-1:0]  r_d4_pos [3], r_d5_pos [3], r_d6_pos [3];
    logic signed [CW-1:0]  r_d1_up [3], r_d2_up [3], r_d3_up [3], r_d4_up [3], r_d5_up [3];
    logic signed [EW-1:0]  r_d1_w [3], r_d2_w [3], r_d3_w [3];
    logic signed [EW-1:0]  r_d4_w [3], r_d5_w [3], r_d6_w [3];
    logic signed [PW-1:0]  r_d1_p [3];
    logic signed [SW-1:0]  r_d2_s;
    logic signed [DW-1:0]  r_d3_d;
    logic signed [QPW-1:0] r_d4_dw [3];
    logic signed [NW-1:0]  r_d5_rdw [3];
    logic signed [NW-1:0]  r_d6_r [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d1_ok <= w_n1_ok;
            r_d2_ok <= r_d1_ok;
            r_d3_ok <= r_d2_ok;
            r_d4_ok <= r_d3_ok;
            r_d5_ok <= r_d4_ok;
            r_d6_ok <= r_d5_ok;
            r_d2_s  <= SW'(r_d1_p[0]) + SW'(r_d1_p[1]) + SW'(r_d1_p[2]);
            r_d3_d  <= DW'(f_rnd(XW'(r_d2_s)));
            for (int i = 0; i < 3; i++) begin
                r_d1_pos[i] <= w_n1_pos[i];
                r_d2_pos[i] <= r_d1_pos[i];
                r_d3_pos[i] <= r_d2_pos[i];
                r_d4_pos[i] <= r_d3_pos[i];
                r_d5_pos[i] <= r_d4_pos[i];
                r_d6_pos[i] <= r_d5_pos[i];
                r_d1_up[i]  <= w_n1_up[i];
                r_d2_up[i]  <= r_d1_up[i];
                r_d3_up[i]  <= r_d2_up[i];
                r_d4_up[i]  <= r_d3_up[i];
                r_d5_up[i]  <= r_d4_up[i];
                r_d1_w[i]   <= w_n1_w[i];
                r_d2_w[i]   <= r_d1_w[i];
                r_d3_w[i]   <= r_d2_w[i];
                r_d4_w[i]   <= r_d3_w[i];
                r_d5_w[i]   <= r_d4_w[i];
                r_d6_w[i]   <= r_d5_w[i];
                r_d1_p[i]   <= w_n1_up[i] * w_n1_w[i];
                r_d4_dw[i]  <= r_d3_d * r_d3_w[i];
                r_d5_rdw[i] <= NW'(f_rnd(XW'(r_d4_dw[i])));
                r_d6_r[i]   <= NW'(r_d5_up[i]) - r_d5_rdw[i];
            end
        end
    end

    // Second normalizer: v = normalize(r), position and w ride along
    logic [SB2-1:0]       w_sb2_in;
    logic                 w_n2_v;
    logic                 w_n2_ok;
    logic signed [EW-1:0] w_n2_v_vec [3];
    logic [SB2-1:0]       w_n2_sb;
    logic signed [CW-1:0] w_n2_pos [3];
    logic signed [EW-1:0] w_n2_w   [3];
    logic                 w_n2_okw;

    assign w_sb2_in = {r_d6_pos[0], r_d6_pos[1], r_d6_pos[2],
                       r_d6_w[0], r_d6_w[1], r_d6_w[2], r_d6_ok};

    lavm_norm #(
        .FRAC_BITS (F),
        .SB_W      (SB2)
    ) u_norm_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_d6_v),
        .i_vec   (r_d6_r),
        .i_sb    (w_sb2_in),
        .o_valid (w_n2_v),
        .o_ok    (w_n2_ok),
        .o_vec   (w_n2_v_vec),
        .o_sb    (w_n2_sb)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n2_pos[i] = $signed(w_n2_sb[SB2 - 1 - i * CW -: CW]);
            w_n2_w[i]   = $signed(w_n2_sb[(2 - i) * EW + 1 +: EW]);
        end
        w_n2_okw = w_n2_sb[0];
    end

    // Cross product u = v x w, then translation per row
    logic r_c1_v, r_c2_v, r_c3_v, r_t1_v, r_t2_v, r_t3_v;
    logic r_c1_ok, r_c2_ok, r_c3_ok, r_t1_ok, r_t2_ok, r_t3_ok;
    logic signed [CW-1:0]      r_c1_pos [3], r_c2_pos [3], r_c3_pos [3];
    logic signed [EW-1:0]      r_c1_w [3], r_c2_w [3], r_c3_w [3];
    logic signed [EW-1:0]      r_c1_vv [3], r_c2_vv [3], r_c3_vv [3];
    logic signed [XPW-1:0]     r_c1_cp [6];
    logic signed [XPW:0]       r_c2_cd [3];
    logic signed [EW-1:0]      r_c3_u [3];
    logic signed [EW-1:0]      w_rows [3][3];
    logic signed [EW-1:0]      r_t1_e [3][3], r_t2_e [3][3], r_t3_e [3][3];
    logic signed [PW-1:0]      r_t1_p [3][3];
    logic signed [SW-1:0]      r_t2_s [3];
    logic signed [TRW-1:0]     r_t3_tr [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rows[0][i] = r_c3_u[i];
            w_rows[1][i] = r_c3_vv[i];
            w_rows[2][i] = r_c3_w[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c1_ok <= w_n2_ok & w_n2_okw;
            r_c2_ok <= r_c1_ok;
            r_c3_ok <= r_c2_ok;
            r_t1_ok <= r_c3_ok;
            r_t2_ok <= r_t1_ok;
            r_t3_ok <= r_t2_ok;
            r_c1_cp[0] <= w_n2_v_vec[1] * w_n2_w[2];
            r_c1_cp[1] <= w_n2_v_vec[2] * w_n2_w[1];
            r_c1_cp[2] <= w_n2_v_vec[2] * w_n2_w[0];
            r_c1_cp[3] <= w_n2_v_vec[0] * w_n2_w[2];
            r_c1_cp[4] <= w_n2_v_vec[0] * w_n2_w[1];
            r_c1_cp[5] <= w_n2_v_vec[1] * w_n2_w[0];
            for (int i = 0; i < 3; i++) begin
                r_c1_pos[i] <= w_n2_pos[i];
                r_c2_pos[i] <= r_c1_pos[i];
                r_c3_pos[i] <= r_c2_pos[i];
                r_c1_w[i]   <= w_n2_w[i];
                r_c2_w[i]   <= r_c1_w[i];
                r_c3_w[i]   <= r_c2_w[i];
                r_c1_vv[i]  <= w_n2_v_vec[i];
                r_c2_vv[i]  <= r_c1_vv[i];
                r_c3_vv[i]  <= r_c2_vv[i];
                r_c2_cd[i]  <= (XPW + 1)'(r_c1_cp[2 * i]) - (XPW + 1)'(r_c1_cp[2 * i + 1]);
                r_c3_u[i]   <= f_clamp(f_rnd(XW'(r_c2_cd[i])));
                for (int k = 0; k < 3; k++) begin
                    r_t1_e[k][i] <= w_rows[k][i];
                    r_t2_e[k][i] <= r_t1_e[k][i];
                    r_t3_e[k][i] <= r_t2_e[k][i];
                    r_t1_p[k][i] <= w_rows[k][i] * r_c3_pos[i];
                end
                r_t2_s[i]  <= SW'(r_t1_p[i][0]) + SW'(r_t1_p[i][1]) + SW'(r_t1_p[i][2]);
                r_t3_tr[i] <= TRW'(f_rnd(XW'(r_t2_s[i])));
            end
        end
    end

    // Output register: one item's three rows, sent one per cycle while the receiver is ready
    logic                   r_tl_v;
    lavm_pkg::t_row_idx     r_row;
    logic signed [ENW-1:0]  r_tl_e  [3][3];
    logic signed [SHW-1:0]  r_tl_sh [3];
    logic                   r_tl_dg;
    logic                   w_out_acc;

    assign w_out_acc = r_tl_v & o_row.ready;
    assign w_adv     = !r_tl_v || (o_row.ready && (r_row == lavm_pkg::ROW_W));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tl_dg <= !r_t3_ok;
            for (int k = 0; k < 3; k++) begin
                r_tl_sh[k] <= r_t3_ok ? f_sat_neg(XW'(r_t3_tr[k])) : '0;
                for (int i = 0; i < 3; i++) begin
                    r_tl_e[k][i] <= r_t3_ok ? f_ent(r_t3_e[k][i]) : '0;
                end
            end
        end
    end

    // Valid chain and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_d3_v <= 1'b0;
            r_d4_v <= 1'b0;
            r_d5_v <= 1'b0;
            r_d6_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_c3_v <= 1'b0;
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_tl_v <= 1'b0;
            r_row  <= lavm_pkg::ROW_U;
        end else if (w_adv) begin
            r_d1_v <= w_n1_v;
            r_d2_v <= r_d1_v;
            r_d3_v <= r_d2_v;
            r_d4_v <= r_d3_v;
            r_d5_v <= r_d4_v;
            r_d6_v <= r_d5_v;
            r_c1_v <= w_n2_v;
            r_c2_v <= r_c1_v;
            r_c3_v <= r_c2_v;
            r_t1_v <= r_c3_v;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            r_tl_v <= r_t3_v;
            r_row  <= lavm_pkg::ROW_U;
        end else if (w_out_acc) begin
            r_row <= r_row + lavm_pkg::t_row_idx'(1);
        end
    end

    // Row select
    always_comb begin
        unique case (r_row)
            lavm_pkg::ROW_U: begin
                o_row.entry_x    = r_tl_e[0][0];
                o_row.entry_y    = r_tl_e[0][1];
                o_row.entry_z    = r_tl_e[0][2];
                o_row.shift_term = r_tl_sh[0];
            end
            lavm_pkg::ROW_V: begin
                o_row.entry_x    = r_tl_e[1][0];
                o_row.entry_y    = r_tl_e[1][1];
                o_row.entry_z    = r_tl_e[1][2];
                o_row.shift_term = r_tl_sh[1];
            end
            lavm_pkg::ROW_W: begin
                o_row.entry_x    = r_tl_e[2][0];
                o_row.entry_y    = r_tl_e[2][1];
                o_row.entry_z    = r_tl_e[2][2];
                o_row.shift_term = r_tl_sh[2];
            end
            default: begin
                o_row.entry_x    = '0;
                o_row.entry_y    = '0;
                o_row.entry_z    = '0;
                o_row.shift_term = '0;
            end
        endcase
    end

    assign i_cam.ready     = w_adv;
    assign o_row.valid     = r_tl_v;
    assign o_row.row_index = r_row;
    assign o_row.degenerate = r_tl_dg;
    assign o_row.last_row  = (r_row == lavm_pkg::ROW_W);

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for look_at_view_matrix: drives camera items, predicts the
// u, v, w rows in fixed point and checks every row item. Needs lavm_pkg, lavm_if and look_at_view_matrix.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = 16;
    localparam int WD_LIMIT = 4000;
    localparam int HOLD_LEN = 500;

    typedef logic signed [lavm_pkg::COORD_WIDTH-1:0] t_coord;

    typedef struct {
        t_coord pos[3];
        t_coord look[3];
        t_coord up[3];
    } t_cam;

    typedef struct {
        lavm_pkg::t_row_idx                       row_index;
        logic signed [lavm_pkg::ENTRY_WIDTH-1:0]  entry_x;
        logic signed [lavm_pkg::ENTRY_WIDTH-1:0]  entry_y;
        logic signed [lavm_pkg::ENTRY_WIDTH-1:0]  entry_z;
        logic signed [lavm_pkg::SHIFT_WIDTH-1:0]  shift_term;
        logic                                     degenerate;
        logic                                     last_row;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lavm_cam_if cam ();
    lavm_row_if row ();

    look_at_view_matrix #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cam   (cam.sink),
        .o_row   (row.source)
    );

    always #6 i_clk = ~i_clk;

    t_cam pending_cams[$];
    t_row rows_due[$];
    t_cam held_cam;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   hold_seq = 0;
    int   hold_seen = 0;
    int   hold_cnt = 0;
    int   quiet_cycles = 0;
    int   n_errors = 0;
    int   n_cams = 0;
    int   n_rows = 0;
    int   n_degen = 0;

    // Round a Q-format product back down, ties away from zero
    function automatic longint rnd_q(longint x);
        longint unsigned half;
        half = 64'd1 << (FRAC - 1);
        if (x >= 0) return longint'((unsigned'(x) + half) >> FRAC);
        return -longint'((unsigned'(-x) + half) >> FRAC);
    endfunction

    function automatic longint clamp_unit(longint x);
        longint one;
        one = longint'(1) << FRAC;
        if (x > one) return one;
        if (x < -one) return -one;
        return x;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit vector of an integer vector; returns 0 for the zero vector
    function automatic bit unit_vec(input longint vin[3], output longint vout[3]);
        longint unsigned mag[3], m, sum, len, q;
        bit neg[3];
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = vin[i] < 0;
            mag[i] = neg[i] ? unsigned'(-vin[i]) : unsigned'(vin[i]);
            if (mag[i] > m) m = mag[i];
            vout[i] = 0;
        end
        if (m == 0) return 0;
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = isqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FRAC) + (len >> 1)) / len;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            vout[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    // Build the three view rows of one camera item and queue them
    function automatic void queue_view_rows(t_cam c);
        longint p[3], up[3], nl[3], r[3], m[3][3], d, t;
        bit ok;
        t_row e;
        for (int i = 0; i < 3; i++) begin
            p[i]  = longint'(c.pos[i]);
            up[i] = longint'(c.up[i]);
            nl[i] = -longint'(c.look[i]);
            m[0][i] = 0;
        end
        ok = unit_vec(nl, m[2]);
        if (ok) begin
            d = rnd_q(up[0] * m[2][0] + up[1] * m[2][1] + up[2] * m[2][2]);
            for (int i = 0; i < 3; i++) r[i] = up[i] - rnd_q(d * m[2][i]);
            ok = unit_vec(r, m[1]);
        end
        if (ok) begin
            m[0][0] = clamp_unit(rnd_q(m[1][1] * m[2][2] - m[1][2] * m[2][1]));
            m[0][1] = clamp_unit(rnd_q(m[1][2] * m[2][0] - m[1][0] * m[2][2]));
            m[0][2] = clamp_unit(rnd_q(m[1][0] * m[2][1] - m[1][1] * m[2][0]));
        end
        if (!ok) n_degen++;
        for (int k = 0; k < 3; k++) begin
            t = 0;
            if (ok) begin
                t = -rnd_q(m[k][0] * p[0] + m[k][1] * p[1] + m[k][2] * p[2]);
                if (t > 64'sd2147483647) t = 64'sd2147483647;
                if (t < -64'sd2147483648) t = -64'sd2147483648;
            end
            e.row_index  = lavm_pkg::t_row_idx'(k);
            e.entry_x    = ok ? m[k][0][lavm_pkg::ENTRY_WIDTH-1:0] : '0;
            e.entry_y    = ok ? m[k][1][lavm_pkg::ENTRY_WIDTH-1:0] : '0;
            e.entry_z    = ok ? m[k][2][lavm_pkg::ENTRY_WIDTH-1:0] : '0;
            e.shift_term = t[lavm_pkg::SHIFT_WIDTH-1:0];
            e.degenerate = !ok;
            e.last_row   = (lavm_pkg::t_row_idx'(k) == lavm_pkg::ROW_W);
            rows_due.push_back(e);
        end
    endfunction

    // Random coordinate of a chosen magnitude class
    function automatic t_coord rand_coord(int span);
        int unsigned raw;
        raw = $urandom;
        if (span >= 32) return t_coord'(raw);
        return t_coord'($signed(raw) >>> (32 - span));
    endfunction

    function automatic t_cam make_cam(t_coord a, t_coord b, t_coord c, t_coord lx,
                                      t_coord ly, t_coord lz, t_coord ux, t_coord uy,
                                      t_coord uz);
        t_cam x;
        x.pos  = '{a, b, c};
        x.look = '{lx, ly, lz};
        x.up   = '{ux, uy, uz};
        return x;
    endfunction

    // Mostly sensible cameras with random scale, some raw noise and parallel up
    function automatic t_cam rand_cam();
        t_cam x;
        int sp, sl, su, kind;
        kind = $urandom_range(9);
        sp = $urandom_range(32, 8);
        sl = $urandom_range(32, 2);
        su = $urandom_range(32, 2);
        for (int i = 0; i < 3; i++) begin
            x.pos[i]  = rand_coord(kind == 0 ? 32 : sp);
            x.look[i] = rand_coord(kind == 0 ? 32 : sl);
            x.up[i]   = rand_coord(kind == 0 ? 32 : su);
        end
        if (kind == 1) x.up = x.look;
        if (kind == 2) for (int i = 0; i < 3; i++) x.up[i] = -x.look[i];
        if (kind == 3) x.look[$urandom_range(2)] = '0;
        return x;
    endfunction

    // Camera driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cam.valid <= 1'b0;
        end else begin
            if (cam.valid && cam.ready) begin
                queue_view_rows(held_cam);
                n_cams++;
            end
            if (!cam.valid || cam.ready) begin
                if (pending_cams.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_cam = pending_cams.pop_front();
                    cam.pos_x  <= held_cam.pos[0];
                    cam.pos_y  <= held_cam.pos[1];
                    cam.pos_z  <= held_cam.pos[2];
                    cam.look_x <= held_cam.look[0];
                    cam.look_y <= held_cam.look[1];
                    cam.look_z <= held_cam.look[2];
                    cam.up_x   <= held_cam.up[0];
                    cam.up_y   <= held_cam.up[1];
                    cam.up_z   <= held_cam.up[2];
                    cam.valid  <= 1'b1;
                end else begin
                    cam.valid <= 1'b0;
                end
            end
        end
    end

    // Row monitor, receiver stalls and watchdog
    always @(posedge i_clk) begin
        t_row got, want;
        if (!i_rst_n) begin
            row.ready <= 1'b0;
        end else begin
            if ((cam.valid && cam.ready) || (row.valid && row.ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", WD_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                if (row.valid && row.ready) begin
                    got = '{row.row_index, row.entry_x, row.entry_y, row.entry_z,
                            row.shift_term, row.degenerate, row.last_row};
                    n_rows++;
                    if (rows_due.size() == 0) begin
                        $error("row item with nothing expected");
                        n_errors++;
                    end else begin
                        want = rows_due.pop_front();
                        if (got.row_index !== want.row_index) begin
                            $error("row_index exp %0d got %0d", want.row_index, got.row_index);
                            n_errors++;
                        end
                        if (got.entry_x !== want.entry_x) begin
                            $error("entry_x exp %0d got %0d", want.entry_x, got.entry_x);
                            n_errors++;
                        end
                        if (got.entry_y !== want.entry_y) begin
                            $error("entry_y exp %0d got %0d", want.entry_y, got.entry_y);
                            n_errors++;
                        end
                        if (got.entry_z !== want.entry_z) begin
                            $error("entry_z exp %0d got %0d", want.entry_z, got.entry_z);
                            n_errors++;
                        end
                        if (got.shift_term !== want.shift_term) begin
                            $error("shift_term exp %0d got %0d", want.shift_term,
                                   got.shift_term);
                            n_errors++;
                        end
                        if (got.degenerate !== want.degenerate) begin
                            $error("degenerate exp %0d got %0d", want.degenerate,
                                   got.degenerate);
                            n_errors++;
                        end
                        if (got.last_row !== want.last_row) begin
                            $error("last_row exp %0d got %0d", want.last_row, got.last_row);
                            n_errors++;
                        end
                    end
                end
                // long hold-off on request, random stalls otherwise
                if (hold_seq != hold_seen) begin
                    hold_seen = hold_seq;
                    hold_cnt = HOLD_LEN;
                end
                if (hold_cnt > 0) begin
                    hold_cnt--;
                    row.ready <= 1'b0;
                end else begin
                    row.ready <= ($urandom_range(99) >= stall_pct);
                end
            end
        end
    end

    task automatic drain_all();
        while (pending_cams.size() != 0 || cam.valid || rows_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_cams.push_back(rand_cam());
    endtask

    localparam t_coord CMAX = 32'sh7fffffff;
    localparam t_coord CMIN = 32'sh80000000;
    localparam t_coord ONE  = 32'sh00010000;

    initial begin
        cam.valid = 1'b0;
        cam.pos_x = '0; cam.pos_y = '0; cam.pos_z = '0;
        cam.look_x = '0; cam.look_y = '0; cam.look_z = '0;
        cam.up_x = '0; cam.up_y = '0; cam.up_z = '0;
        row.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: textbook camera, zero look, parallel up, zero up, extremes
        pending_cams.push_back(make_cam(0, 0, 5 * ONE, 0, 0, -ONE, 0, ONE, 0));
        pending_cams.push_back(make_cam(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0));
        pending_cams.push_back(make_cam(ONE, ONE, ONE, ONE, 2, 3, 2 * ONE, 4, 6));
        pending_cams.push_back(make_cam(ONE, ONE, ONE, ONE, 0, 0, -3 * ONE, 0, 0));
        pending_cams.push_back(make_cam(ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 0));
        pending_cams.push_back(make_cam(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 0, CMAX));
        pending_cams.push_back(make_cam(CMIN, CMIN, CMIN, CMAX, 0, 0, 0, CMAX, 0));
        pending_cams.push_back(make_cam(CMAX, CMIN, CMAX, 1, 1, 1, -1, 1, 0));
        pending_cams.push_back(make_cam(CMIN, CMAX, CMIN, 0, 0, 1, 1, 0, 0));
        pending_cams.push_back(make_cam(CMAX, CMAX, CMAX, -1, -1, -1, CMIN, CMAX, 1));
        pending_cams.push_back(make_cam(-1, -1, -1, CMIN, 0, 0, 0, CMIN, 0));
        pending_cams.push_back(make_cam(0, 0, 0, 0, 0, CMIN, CMIN, CMIN, CMIN));
        pending_cams.push_back(make_cam(ONE, -ONE, 0, 3, 4, 0, -4, 3, 0));
        pending_cams.push_back(make_cam(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1, 0, 0));
        pending_cams.push_back(make_cam(CMAX, CMAX, CMAX, ONE, ONE, ONE, ONE, ONE, ONE + 1));
        drain_all();

        // phase: no idling
        queue_random(80);
        drain_all();
        // phase: sparse sender
        send_idle_pct = 84;
        queue_random(70);
        drain_all();
        // phase: slow receiver, long hold-off; more items than the pipe holds
        send_idle_pct = 0;
        stall_pct = 84;
        hold_seq++;
        queue_random(150);
        drain_all();
        // phase: both sides idle
        send_idle_pct = 34;
        stall_pct = 34;
        queue_random(70);
        drain_all();

        repeat (300) @(posedge i_clk);
        $display("covered %0d camera items, %0d row items, %0d degenerate cameras",
                 n_cams, n_rows, n_degen);
        $display("phases: free flow, idle sender, stalled receiver with long hold, mixed");
        if (n_errors == 0 && rows_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: filelist.f
hdl/lavm_pkg.sv
hdl/lavm_if.sv
hdl/lavm_norm.sv
hdl/look_at_view_matrix.sv
bench/tb.sv
